// ----- src/nrpn_dec_pkg.sv -----
// Types and constants shared by the NRPN decoder modules.
// No dependencies.
package nrpn_dec_pkg;

   // Event code index of a control change
   localparam logic [3:0] CIN_CONTROL_CHANGE = 4'hB;

   // Controller numbers
   localparam logic [6:0] CC_NRPN_LSB = 7'd98;
   localparam logic [6:0] CC_NRPN_MSB = 7'd99;
   localparam logic [6:0] CC_RPN_LSB  = 7'd100;
   localparam logic [6:0] CC_RPN_MSB  = 7'd101;
   localparam logic [6:0] CC_DATA_LSB = 7'd38;
   localparam logic [6:0] CC_DATA_MSB = 7'd6;

   // Register file
   localparam int          CSR_ADDR_W    = 3;
   localparam int          CSR_DATA_W    = 32;
   localparam logic [0:0]  REG_FREE_MASK = 1'b0;   // word index
   localparam logic [15:0] MASK_RESET    = 16'hFFFE;

   typedef struct packed {
      logic [3:0] code_index;
      logic [3:0] channel;
      logic [6:0] controller;
      logic [6:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [3:0]  out_channel;
      logic [14:0] param_number;
      logic [14:0] param_value;
   } rsp_type;

endpackage

// ----- src/midi_nrpn_decoder.sv -----
// MIDI NRPN decoder top level: request register, per-channel core, result register.
// A request is held in the request register, its result then in the result register.
// Throughput: one request per cycle unless stalled; a channel read-modify-write a cycle.
// A stalled result holds the request register, so at most two requests are in flight.
// Reset (synchronous): parameters undefined, values zero, free mask 0xFFFE.
// Depends on nrpn_dec_pkg and nrpn_dec_core.
module midi_nrpn_decoder #(
   parameter int NUM_CHANNELS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  nrpn_dec_pkg::req_type                req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output nrpn_dec_pkg::rsp_type                rsp_data,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [nrpn_dec_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [nrpn_dec_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [nrpn_dec_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                                 pready
);
   import nrpn_dec_pkg::*;

   logic        in_valid_ff, in_valid_in;
   req_type     in_data_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff;
   logic [15:0] free_mask_ff, free_mask_in;

   logic        advance, fire, take, hit, mask_wr, mask_sel;
   rsp_type     core_rsp;

   // Register file
   assign pready   = 1'b1;
   assign mask_sel = paddr[CSR_ADDR_W-1:2] == REG_FREE_MASK;
   assign mask_wr  = psel && penable && pwrite && mask_sel;
   assign free_mask_in = mask_wr ? pwdata[15:0] : free_mask_ff;
   assign prdata   = mask_sel ? {{(CSR_DATA_W-16){1'b0}}, free_mask_ff} : '0;

   // Pipeline control
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign take      = req_valid && !req_stall;

   assign in_valid_in  = take ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = advance ? hit : rsp_valid_ff;

   nrpn_dec_core #(
      .NUM_CHANNELS(NUM_CHANNELS)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .fire     (fire),
      .ev       (in_data_ff),
      .free_mask(free_mask_ff),
      .hit      (hit),
      .rsp      (core_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         free_mask_ff <= MASK_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         free_mask_ff <= free_mask_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_data_ff <= req_data;
      end
      if (advance && hit) begin
         rsp_data_ff <= core_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef ASSERT_OFF
   // A new result only appears when the core dispatched a request
   a_rsp_from_fire: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(fire))
      else $error("result appeared without a dispatch");

   // Stall towards the requester only with a held request and a blocked result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("request stalled without cause");

   // Free mask comes out of reset at its reset value
   a_mask_reset: assert property (@(posedge clock)
      reset |=> (free_mask_ff == MASK_RESET))
      else $error("free mask not reset");
`endif

endmodule

// ----- src/nrpn_dec_core.sv -----
// Per-channel NRPN state and the update / dispatch decision for one event.
// Depends on nrpn_dec_pkg.
module nrpn_dec_core #(
   parameter int NUM_CHANNELS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  nrpn_dec_pkg::req_type ev,
   input  logic [15:0]           free_mask,
   output logic                  hit,
   output nrpn_dec_pkg::rsp_type rsp
);
   import nrpn_dec_pkg::*;

   localparam int         IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam logic [4:0] NUM_CH = 5'(NUM_CHANNELS);

   // Parameter number bytes are 7 bits plus an undefined flag each;
   // the value is held as its two 7-bit halves (bit 0 is always zero).
   logic [6:0] hi_ff       [NUM_CHANNELS];
   logic       hi_undef_ff [NUM_CHANNELS];
   logic [6:0] lo_ff       [NUM_CHANNELS];
   logic       lo_undef_ff [NUM_CHANNELS];
   logic [6:0] vmsb_ff     [NUM_CHANNELS];
   logic [6:0] vlsb_ff     [NUM_CHANNELS];

   logic [6:0] hi_in, lo_in, vmsb_in, vlsb_in;
   logic       hi_undef_in, lo_undef_in;

   logic [IDX_W-1:0] idx;
   logic             act;
   logic             in_range;

   assign idx      = ev.channel[IDX_W-1:0];
   assign in_range = {1'b0, ev.channel} < NUM_CH;
   assign act      = fire && (ev.code_index == CIN_CONTROL_CHANGE) && in_range;

   always_comb begin
      hi_in       = hi_ff[idx];
      hi_undef_in = hi_undef_ff[idx];
      lo_in       = lo_ff[idx];
      lo_undef_in = lo_undef_ff[idx];
      vmsb_in     = vmsb_ff[idx];
      vlsb_in     = vlsb_ff[idx];
      unique case (ev.controller)
         CC_NRPN_LSB: begin
            lo_in       = ev.data_byte;
            lo_undef_in = 1'b0;
            vmsb_in     = '0;
            vlsb_in     = '0;
         end
         CC_NRPN_MSB: begin
            hi_in       = ev.data_byte;
            hi_undef_in = 1'b0;
            vmsb_in     = '0;
            vlsb_in     = '0;
         end
         CC_RPN_LSB, CC_RPN_MSB: begin
            hi_undef_in = 1'b1;
            lo_undef_in = 1'b1;
            vmsb_in     = '0;
            vlsb_in     = '0;
         end
         CC_DATA_LSB: begin
            vlsb_in = ev.data_byte;
         end
         CC_DATA_MSB: begin
            vmsb_in = ev.data_byte;
         end
         default: begin
         end
      endcase
   end

   // Dispatch only on data entry MSB with both bytes defined on a served channel
   assign hit = act && (ev.controller == CC_DATA_MSB) && !hi_undef_ff[idx]
                && !lo_undef_ff[idx] && !free_mask[ev.channel];

   assign rsp.out_channel  = ev.channel;
   assign rsp.param_number = {hi_ff[idx], 1'b0, lo_ff[idx]};
   assign rsp.param_value  = {ev.data_byte, vlsb_ff[idx], 1'b0};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            hi_ff[i]       <= '0;
            hi_undef_ff[i] <= 1'b1;
            lo_ff[i]       <= '0;
            lo_undef_ff[i] <= 1'b1;
            vmsb_ff[i]     <= '0;
            vlsb_ff[i]     <= '0;
         end
      end else if (act) begin
         hi_ff[idx]       <= hi_in;
         hi_undef_ff[idx] <= hi_undef_in;
         lo_ff[idx]       <= lo_in;
         lo_undef_ff[idx] <= lo_undef_in;
         vmsb_ff[idx]     <= vmsb_in;
         vlsb_ff[idx]     <= vlsb_in;
      end
   end

endmodule
